// ===== rtl/krt_pkg.sv =====
// ----------------------------------------------------------------------------
// krt_pkg
// Shared types and constants for the keyed record table.
// ----------------------------------------------------------------------------
package krt_pkg;

  localparam int DEPTH  = 64;
  localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int DATA_W = 32;
  localparam int CMD_W  = 2;
  localparam int STAT_W = 3;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_SEARCH = 2'd1,
    CMD_UPDATE = 2'd2,
    CMD_LIST   = 2'd3
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_DUPLICATE = 3'd2,
    ST_FULL      = 3'd3,
    ST_EMPTY     = 3'd4
  } status_t;

  // source of the key/quantity fields of a result
  typedef enum logic [1:0] {
    SEL_FAIL = 2'd0,   // zeros
    SEL_REQ  = 2'd1,   // request key and quantity
    SEL_RD   = 2'd2,   // stored record
    SEL_SUM  = 2'd3    // stored key, updated quantity
  } emit_sel_t;

  // controller -> datapath
  typedef struct packed {
    logic      load_req;
    logic      clr_idx;
    logic      inc_idx;
    logic      wr_qty;
    logic      append;
    logic      emit;
    status_t   emit_status;
    emit_sel_t emit_sel;
    logic      emit_last;
  } ctrl_t;

  // datapath -> controller
  typedef struct packed {
    cmd_t command;
    logic empty;
    logic full;
    logic match;
    logic at_last;
    logic out_free;
  } stat_t;

endpackage

// ===== rtl/krt_if.sv =====
// ----------------------------------------------------------------------------
// krt_req_if / krt_rsp_if
// Valid/ready channels for table requests and results.
// ----------------------------------------------------------------------------
interface krt_req_if;
  logic                              valid;
  logic                              ready;
  logic [krt_pkg::CMD_W-1:0]         command;
  logic signed [krt_pkg::DATA_W-1:0] part_key;
  logic signed [krt_pkg::DATA_W-1:0] quantity;

  modport source (output valid, command, part_key, quantity, input ready);
  modport sink   (input valid, command, part_key, quantity, output ready);
endinterface

interface krt_rsp_if;
  logic                              valid;
  logic                              ready;
  logic [krt_pkg::STAT_W-1:0]        status;
  logic signed [krt_pkg::DATA_W-1:0] record_key;
  logic signed [krt_pkg::DATA_W-1:0] record_quantity;
  logic                              last;

  modport source (output valid, status, record_key, record_quantity, last, input ready);
  modport sink   (input valid, status, record_key, record_quantity, last, output ready);
endinterface

// ===== rtl/krt_ctrl.sv =====
// ----------------------------------------------------------------------------
// krt_ctrl
// Sequencer: dispatches a request, steps the scan, issues results.
// ----------------------------------------------------------------------------
module krt_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_ready,
  input  krt_pkg::stat_t  sts,
  output krt_pkg::ctrl_t  ctrl
);
  import krt_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE     = 4'b0001,
    S_DISPATCH = 4'b0010,
    S_READ     = 4'b0100,
    S_CHECK    = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next       = state;
    req_ready        = 1'b0;
    ctrl             = '0;
    ctrl.emit_status = ST_OK;
    ctrl.emit_sel    = SEL_FAIL;
    ctrl.emit_last   = 1'b1;
    case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          ctrl.load_req = 1'b1;
          ctrl.clr_idx  = 1'b1;
          state_next    = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (sts.command)
          CMD_LIST: begin
            if (!sts.empty) begin
              state_next = S_READ;
            end else if (sts.out_free) begin
              ctrl.emit        = 1'b1;
              ctrl.emit_status = ST_EMPTY;
              state_next       = S_IDLE;
            end
          end
          CMD_INSERT: begin
            if (sts.full) begin
              if (sts.out_free) begin
                ctrl.emit        = 1'b1;
                ctrl.emit_status = ST_FULL;
                state_next       = S_IDLE;
              end
            end else if (!sts.empty) begin
              state_next = S_READ;
            end else if (sts.out_free) begin
              ctrl.append   = 1'b1;
              ctrl.emit     = 1'b1;
              ctrl.emit_sel = SEL_REQ;
              state_next    = S_IDLE;
            end
          end
          default: begin
            if (!sts.empty) begin
              state_next = S_READ;
            end else if (sts.out_free) begin
              ctrl.emit        = 1'b1;
              ctrl.emit_status = ST_NOT_FOUND;
              state_next       = S_IDLE;
            end
          end
        endcase
      end
      S_READ: begin
        state_next = S_CHECK;
      end
      S_CHECK: begin
        if (sts.command == CMD_LIST) begin
          if (sts.out_free) begin
            ctrl.emit      = 1'b1;
            ctrl.emit_sel  = SEL_RD;
            ctrl.emit_last = sts.at_last;
            if (sts.at_last) begin
              state_next = S_IDLE;
            end else begin
              ctrl.inc_idx = 1'b1;
              state_next   = S_READ;
            end
          end
        end else if (!sts.match && !sts.at_last) begin
          ctrl.inc_idx = 1'b1;
          state_next   = S_READ;
        end else if (sts.out_free) begin
          ctrl.emit  = 1'b1;
          state_next = S_IDLE;
          case (sts.command)
            CMD_INSERT: begin
              if (sts.match) begin
                ctrl.emit_status = ST_DUPLICATE;
              end else begin
                ctrl.append   = 1'b1;
                ctrl.emit_sel = SEL_REQ;
              end
            end
            CMD_UPDATE: begin
              if (sts.match) begin
                ctrl.wr_qty   = 1'b1;
                ctrl.emit_sel = SEL_SUM;
              end else begin
                ctrl.emit_status = ST_NOT_FOUND;
              end
            end
            default: begin
              if (sts.match) begin
                ctrl.emit_sel = SEL_RD;
              end else begin
                ctrl.emit_status = ST_NOT_FOUND;
              end
            end
          endcase
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/krt_datapath.sv =====
// ----------------------------------------------------------------------------
// krt_datapath
// Record memories, request holding registers, scan index, result register.
// ----------------------------------------------------------------------------
module krt_datapath (
  input  logic                              clk,
  input  logic                              rst,
  input  krt_pkg::ctrl_t                    ctrl,
  output krt_pkg::stat_t                    sts,
  input  logic [krt_pkg::CMD_W-1:0]         req_command,
  input  logic signed [krt_pkg::DATA_W-1:0] req_part_key,
  input  logic signed [krt_pkg::DATA_W-1:0] req_quantity,
  input  logic                              rsp_ready,
  output logic                              rsp_valid,
  output logic [krt_pkg::STAT_W-1:0]        rsp_status,
  output logic signed [krt_pkg::DATA_W-1:0] rsp_record_key,
  output logic signed [krt_pkg::DATA_W-1:0] rsp_record_quantity,
  output logic                              rsp_last
);
  import krt_pkg::*;

  logic signed [DATA_W-1:0] key_store [DEPTH];
  logic signed [DATA_W-1:0] quantity_store [DEPTH];

  cmd_t                     cmd;
  logic signed [DATA_W-1:0] key;
  logic signed [DATA_W-1:0] qty;
  logic [CNT_W-1:0]         entry_count;
  logic [IDX_W-1:0]         idx;
  logic signed [DATA_W-1:0] rd_key;
  logic signed [DATA_W-1:0] rd_qty;

  logic [DATA_W:0]          sum_wide;
  logic signed [DATA_W-1:0] sum;
  logic [IDX_W-1:0]         wr_addr;
  logic signed [DATA_W-1:0] wr_qty_data;

  // saturating add of stored quantity and delta
  always_comb begin
    sum_wide = {rd_qty[DATA_W-1], rd_qty} + {qty[DATA_W-1], qty};
    if (sum_wide[DATA_W] != sum_wide[DATA_W-1]) begin
      sum = sum_wide[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
    end else begin
      sum = sum_wide[DATA_W-1:0];
    end
  end

  assign wr_addr     = ctrl.append ? entry_count[IDX_W-1:0] : idx;
  assign wr_qty_data = ctrl.append ? qty : sum;

  always_ff @(posedge clk) begin
    if (ctrl.append) begin
      key_store[wr_addr] <= key;
    end
    if (ctrl.append || ctrl.wr_qty) begin
      quantity_store[wr_addr] <= wr_qty_data;
    end
    rd_key <= key_store[idx];
    rd_qty <= quantity_store[idx];
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_req) begin
      cmd <= cmd_t'(req_command);
      key <= req_part_key;
      qty <= req_quantity;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
      idx         <= '0;
    end else begin
      if (ctrl.append) begin
        entry_count <= entry_count + CNT_W'(1);
      end
      if (ctrl.clr_idx) begin
        idx <= '0;
      end else if (ctrl.inc_idx) begin
        idx <= idx + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (ctrl.emit) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.emit) begin
      rsp_status <= ctrl.emit_status;
      rsp_last   <= ctrl.emit_last;
      case (ctrl.emit_sel)
        SEL_REQ: begin
          rsp_record_key      <= key;
          rsp_record_quantity <= qty;
        end
        SEL_RD: begin
          rsp_record_key      <= rd_key;
          rsp_record_quantity <= rd_qty;
        end
        SEL_SUM: begin
          rsp_record_key      <= rd_key;
          rsp_record_quantity <= sum;
        end
        default: begin
          rsp_record_key      <= '0;
          rsp_record_quantity <= '0;
        end
      endcase
    end
  end

  assign sts.command  = cmd;
  assign sts.empty    = (entry_count == '0);
  assign sts.full     = (entry_count == CNT_W'(DEPTH));
  assign sts.match    = (rd_key == key);
  assign sts.at_last  = (CNT_W'(idx) == entry_count - CNT_W'(1));
  assign sts.out_free = !rsp_valid || rsp_ready;

endmodule

// ===== rtl/keyed_record_table.sv =====
// ----------------------------------------------------------------------------
// keyed_record_table
// Linear-search key/quantity table with insert, search, update and list.
// ----------------------------------------------------------------------------
// One request is handled at a time: req.ready is high only while the block
// is idle. A request is dispatched, then every stored record visited is read
// from a memory with a registered read and compared against the key before
// stepping on. Search, update and insert stop on the first match; insert
// otherwise scans all records to rule out a duplicate (a full table is
// refused without a scan); list visits all records and issues one result
// each. Results leave through an output register; while a result waits
// there the next record is read, but the scan stalls until the register is
// free. On a failed request (not found, duplicate, full, empty) the key
// and quantity fields of the result are zero. Update saturates the quantity
// to the signed 32-bit range.
// ----------------------------------------------------------------------------
module keyed_record_table (
  input  logic      clk,
  input  logic      rst,
  krt_req_if.sink   req,
  krt_rsp_if.source rsp
);
  import krt_pkg::*;

  ctrl_t ctrl;
  stat_t sts;

  // sequencer: FSM only, talks to the datapath through ctrl/sts
  krt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .sts       (sts),
    .ctrl      (ctrl)
  );

  // record memories, scan index, entry count and result register
  krt_datapath u_datapath (
    .clk                 (clk),
    .rst                 (rst),
    .ctrl                (ctrl),
    .sts                 (sts),
    .req_command         (req.command),
    .req_part_key        (req.part_key),
    .req_quantity        (req.quantity),
    .rsp_ready           (rsp.ready),
    .rsp_valid           (rsp.valid),
    .rsp_status          (rsp.status),
    .rsp_record_key      (rsp.record_key),
    .rsp_record_quantity (rsp.record_quantity),
    .rsp_last            (rsp.last)
  );

endmodule

// ===== sim/krt_table_checker.sv =====
// ----------------------------------------------------------------------------
// krt_table_checker
// Watches the request and result channels of the keyed record table, keeps
// its own copy of the table, and compares every result with the predicted one.
// ----------------------------------------------------------------------------
module krt_table_checker
  import krt_pkg::*;
(
  input  logic clk,
  input  logic rst,
  krt_req_if   req,
  krt_rsp_if   rsp,
  output int   failures,
  output int   pending
);

  typedef struct packed {
    status_t                   status;
    logic signed [DATA_W-1:0]  key;
    logic signed [DATA_W-1:0]  qty;
    logic                      last;
  } table_result_t;

  localparam logic signed [DATA_W-1:0] QTY_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] QTY_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  logic signed [DATA_W-1:0] stock_key [DEPTH];
  logic signed [DATA_W-1:0] stock_qty [DEPTH];
  int                       stock_count;
  table_result_t            due_results [$];

  function automatic void push_result(input status_t status,
                                      input logic signed [DATA_W-1:0] key,
                                      input logic signed [DATA_W-1:0] qty,
                                      input logic last);
    table_result_t r;
    r.status = status;
    r.key    = key;
    r.qty    = qty;
    r.last   = last;
    due_results.push_back(r);
  endfunction

  // oldest record holding the key, -1 when absent
  function automatic int find_key(input logic signed [DATA_W-1:0] key);
    for (int i = 0; i < stock_count; i++) begin
      if (stock_key[i] == key) return i;
    end
    return -1;
  endfunction

  function automatic void book_request(input cmd_t cmd,
                                       input logic signed [DATA_W-1:0] key,
                                       input logic signed [DATA_W-1:0] qty);
    int                     idx;
    logic signed [DATA_W:0] total;
    idx = find_key(key);
    case (cmd)
      CMD_INSERT: begin
        // fullness wins over a duplicate key
        if (stock_count >= DEPTH) begin
          push_result(ST_FULL, '0, '0, 1'b1);
        end else if (idx >= 0) begin
          push_result(ST_DUPLICATE, '0, '0, 1'b1);
        end else begin
          stock_key[stock_count] = key;
          stock_qty[stock_count] = qty;
          stock_count++;
          push_result(ST_OK, key, qty, 1'b1);
        end
      end
      CMD_SEARCH: begin
        if (idx < 0) push_result(ST_NOT_FOUND, '0, '0, 1'b1);
        else push_result(ST_OK, stock_key[idx], stock_qty[idx], 1'b1);
      end
      CMD_UPDATE: begin
        if (idx < 0) begin
          push_result(ST_NOT_FOUND, '0, '0, 1'b1);
        end else begin
          total = stock_qty[idx] + qty;
          if (total[DATA_W] != total[DATA_W-1]) begin
            stock_qty[idx] = total[DATA_W] ? QTY_MIN : QTY_MAX;
          end else begin
            stock_qty[idx] = total[DATA_W-1:0];
          end
          push_result(ST_OK, stock_key[idx], stock_qty[idx], 1'b1);
        end
      end
      default: begin
        if (stock_count == 0) begin
          push_result(ST_EMPTY, '0, '0, 1'b1);
        end else begin
          for (int i = 0; i < stock_count; i++) begin
            push_result(ST_OK, stock_key[i], stock_qty[i], i == stock_count - 1);
          end
        end
      end
    endcase
  endfunction

  function automatic void check_field(input string name, input logic signed [63:0] want,
                                      input logic signed [63:0] got);
    if (got !== want) begin
      $display("%0t %s: expected %0d, got %0d", $time, name, want, got);
      failures++;
    end
  endfunction

  always @(posedge clk) begin
    table_result_t want;
    if (rst) begin
      stock_count = 0;
      due_results.delete();
      failures    = 0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (due_results.size() == 0) begin
          $display("%0t unexpected result: expected none, got status %0d key %0d qty %0d",
                   $time, rsp.status, rsp.record_key, rsp.record_quantity);
          failures++;
        end else begin
          want = due_results.pop_front();
          check_field("status", want.status, rsp.status);
          check_field("record_key", want.key, rsp.record_key);
          check_field("record_quantity", want.qty, rsp.record_quantity);
          check_field("last", want.last, rsp.last);
        end
      end
      if (req.valid && req.ready) begin
        book_request(cmd_t'(req.command), req.part_key, req.quantity);
      end
    end
    pending <= due_results.size();
  end

endmodule

// ===== sim/keyed_record_table_tb.sv =====
// ----------------------------------------------------------------------------
// keyed_record_table_tb
// Drives insert, search, update and list requests into the keyed record
// table with random gaps and result back-pressure; a checker beside the
// block predicts and compares every result.
// ----------------------------------------------------------------------------
module keyed_record_table_tb;
  import krt_pkg::*;

  localparam int DIRECTED_ITEMS = 20;
  localparam int RANDOM_ITEMS   = 310;
  localparam int TOTAL_ITEMS    = DIRECTED_ITEMS + RANDOM_ITEMS;
  // Sized for the worst case: 330 requests, each a full scan with 64 results
  // held back by the receiver and an idle gap before it.
  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  // receiver hold-off that backs the block up into the request channel
  localparam int HOLD_AT_ITEM   = 150;
  localparam int HOLD_CYCLES    = 600;

  localparam logic signed [DATA_W-1:0] VAL_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] VAL_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  int          items_sent = 0;
  int unsigned cycle_count = 0;
  int          failures;
  int          pending;

  // keys sent with insert requests; searches and updates mostly reuse them
  logic signed [DATA_W-1:0] used_keys [$];

  krt_req_if req_ch ();
  krt_rsp_if rsp_ch ();

  keyed_record_table i_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  krt_table_checker i_check (
    .clk      (clk),
    .rst      (rst),
    .req      (req_ch),
    .rsp      (rsp_ch),
    .failures (failures),
    .pending  (pending)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // synchronous reset, held once at the start
  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
  end

  // hard stop for a hung block
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("keyed_record_table: mismatch");
      $finish;
    end
  end

  // Idling is off for a stretch in the middle and for the closing stretch,
  // so back-to-back traffic gets exercised too.
  function automatic bit idling_allowed();
    return !(items_sent >= 60 && items_sent < 90) && items_sent < TOTAL_ITEMS - 40;
  endfunction

  // Mostly full-range random values, with the saturation corners mixed in.
  function automatic logic signed [DATA_W-1:0] pick_qty();
    if ($urandom_range(0, 99) < 15) begin
      case ($urandom_range(0, 4))
        0:       return VAL_MAX;
        1:       return VAL_MIN;
        2:       return '0;
        3:       return -1;
        default: return 1;
      endcase
    end
    return $urandom;
  endfunction

  // fresh_pct: chance of a brand-new random key instead of one already used
  function automatic logic signed [DATA_W-1:0] pick_key(input int fresh_pct);
    if (used_keys.size() == 0 || $urandom_range(0, 99) < fresh_pct) return $urandom;
    return used_keys[$urandom_range(0, used_keys.size() - 1)];
  endfunction

  // Offer one request, maybe after an idle burst, and hold it until accepted.
  // The checker picks it up off the channel; nothing is predicted here.
  task automatic offer_request(input cmd_t cmd, input logic signed [DATA_W-1:0] key,
                               input logic signed [DATA_W-1:0] qty);
    if (idling_allowed() && $urandom_range(0, 3) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    req_ch.valid    <= 1'b1;
    req_ch.command  <= cmd;
    req_ch.part_key <= key;
    req_ch.quantity <= qty;
    if (cmd == CMD_INSERT) used_keys.push_back(key);
    do @(posedge clk); while (!req_ch.ready);
    items_sent <= items_sent + 1;
  endtask

  // Result side: random stall bursts, plus one long hold-off once the run is
  // well underway. The block serves one request at a time, so a held result
  // register stops the scan and req.ready drops while the sender keeps trying.
  initial begin
    int stall;
    bit held;
    stall = 0;
    held  = 1'b0;
    rsp_ch.ready <= 1'b0;
    while (rst) @(posedge clk);
    forever begin
      if (!held && items_sent >= HOLD_AT_ITEM) begin
        held  = 1'b1;
        stall = HOLD_CYCLES;
      end else if (stall == 0 && idling_allowed() && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(1, 17);
      end
      if (stall > 0) begin
        rsp_ch.ready <= 1'b0;
        stall--;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
      @(posedge clk);
    end
  end

  // Request side and verdict.
  initial begin
    int   pick;
    cmd_t cmd;
    req_ch.valid    <= 1'b0;
    req_ch.command  <= CMD_INSERT;
    req_ch.part_key <= '0;
    req_ch.quantity <= '0;
    while (rst) @(posedge clk);

    // --- directed part ---
    // everything on an empty table: list gives the empty status,
    // search and update miss
    offer_request(CMD_LIST, '0, '0);
    offer_request(CMD_SEARCH, '0, '0);
    offer_request(CMD_UPDATE, 5, 1);
    // extreme keys and quantities
    offer_request(CMD_INSERT, VAL_MIN, VAL_MAX);
    offer_request(CMD_INSERT, VAL_MAX, VAL_MIN);
    offer_request(CMD_INSERT, '0, '0);
    offer_request(CMD_INSERT, -1, -1);
    // duplicate key is refused, table unchanged
    offer_request(CMD_INSERT, VAL_MAX, 7);
    offer_request(CMD_SEARCH, VAL_MIN, '0);
    offer_request(CMD_SEARCH, 12345, '0);
    // saturation: max+1 clips high, min-1 clips low
    offer_request(CMD_UPDATE, VAL_MIN, 1);
    offer_request(CMD_UPDATE, VAL_MAX, -1);
    // 0 -> max -> -1 without clipping, then -1 + min clips low
    offer_request(CMD_UPDATE, '0, VAL_MAX);
    offer_request(CMD_UPDATE, '0, VAL_MIN);
    offer_request(CMD_UPDATE, -1, VAL_MIN);
    offer_request(CMD_UPDATE, '0, '0);
    offer_request(CMD_LIST, '0, '0);
    // alternating bit patterns in both fields
    offer_request(CMD_INSERT, 32'sh5555_5555, 32'shAAAA_AAAA);
    offer_request(CMD_INSERT, 32'shAAAA_AAAA, 32'sh5555_5555);
    offer_request(CMD_LIST, '0, '0);

    // --- random part ---
    // Inserts lean toward fresh keys so the table fills up around the middle
    // of the run; from then on inserts hit the full status, including
    // inserts of keys already present. Lookups mostly reuse stored keys.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 40)      cmd = CMD_INSERT;
      else if (pick < 65) cmd = CMD_SEARCH;
      else if (pick < 88) cmd = CMD_UPDATE;
      else                cmd = CMD_LIST;
      offer_request(cmd, pick_key(cmd == CMD_INSERT ? 80 : 25), pick_qty());
    end
    req_ch.valid <= 1'b0;

    // let the checker's count catch up with the last request, then drain
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    // room for any stray result after the last expected one
    repeat (300) @(posedge clk);

    if (failures == 0 && pending == 0) begin
      $display("keyed_record_table: match");
    end else begin
      $display("keyed_record_table: mismatch");
    end
    $finish;
  end

endmodule
